// ===== hw/rtl/rse_pkg.sv =====
package rse_pkg;

  localparam int RANGE_BITS = 10;
  localparam int CNT_W      = 4;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CNT_W-1:0] AREA_COUNT_RST = 4'd10;

  typedef struct packed {
    logic                  action;
    logic [RANGE_BITS-1:0] range_mask;
    logic                  allowed;
  } req_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] left_range;
    logic [RANGE_BITS-1:0] right_range;
    logic                  none_found;
    logic                  last;
  } rsp_t;

endpackage

// ===== hw/rtl/range_split_enumerator.sv =====
// channel   dir  handshake            word
// req       in   req_valid/req_ready  req_t: action, range_mask, allowed
// rsp       out  rsp_valid/rsp_ready  rsp_t: left_range, right_range, none_found, last
// cfg       in   cfg_we               cfg_data: area_count
//
// a load word is written to memory when accepted; a query scans the areas below lim,
// lim = min(area_count, AREAS, 10): one scan step per area plus four pair slots per
// present area, each slot enabled by the membership memory read for that area;
// a single-area or empty range goes straight to the closing word
// after reset a clearing pass writes every entry allowed, with req_ready low
// rst is synchronous, active high; area_count resets to 10
// a stalled rsp holds the query; one pair is held back so the last one can be marked
module range_split_enumerator import rse_pkg::*; #(
  parameter int AREAS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  localparam int DEPTH = 1 << AREAS;
  localparam int RB    = RANGE_BITS;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [4:0] AREAS_L = 5'(AREAS);
  localparam logic [4:0] RB_L    = 5'(RB);

  logic [2:0]       state;
  logic [AREAS-1:0] clr_cnt;
  logic [CNT_W-1:0] area_count;
  logic [RB-1:0]    range_q;
  logic [RB-1:0]    vmask;
  logic [4:0]       lim;
  logic [3:0]       i;
  logic [1:0]       j;
  rsp_t             pend;
  logic             pend_valid;

  logic             mem [DEPTH];
  logic             rd_x;
  logic             rd_y;

  logic             out_free;
  logic             push;
  rsp_t             push_data;
  logic             req_fire;

  logic [4:0]       n_areas;
  logic [4:0]       lim_next;
  logic [RB-1:0]    vmask_next;
  logic             single;

  logic [RB-1:0]    x;
  logic [RB-1:0]    y;
  logic             y_multi;
  logic             i_lt;
  logic             en_j;
  rsp_t             cand;

  logic                  we;
  logic [AREAS-1:0]      wa;
  logic                  wd;
  logic [RB+AREAS-1:0]   x_ext;
  logic [RB+AREAS-1:0]   y_ext;
  logic [RB+AREAS-1:0]   r_ext;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // query setup from area_count
  always_comb begin
    n_areas  = ({1'b0, area_count} > AREAS_L) ? AREAS_L : {1'b0, area_count};
    lim_next = (n_areas > RB_L) ? RB_L : n_areas;
    for (int k = 0; k < RB; k++) begin
      vmask_next[k] = (5'(k) < n_areas);
    end
    single = (req.range_mask != '0) &&
             ((req.range_mask & (req.range_mask - 1'b1)) == '0);
  end

  // current area and its remainder
  always_comb begin
    x       = RB'(1) << i;
    y       = (x ^ range_q) & vmask;
    y_multi = (y & (y - 1'b1)) != '0;
    i_lt    = {1'b0, i} < lim;
    x_ext   = {{AREAS{1'b0}}, x};
    y_ext   = {{AREAS{1'b0}}, y};
    r_ext   = {{AREAS{1'b0}}, req.range_mask};
  end

  always_comb begin
    cand = '0;
    en_j = 1'b0;
    case (j)
      2'd0: begin
        en_j = rd_x;
        cand.left_range  = x;
        cand.right_range = range_q;
      end
      2'd1: begin
        en_j = rd_x;
        cand.left_range  = range_q;
        cand.right_range = x;
      end
      2'd2: begin
        en_j = rd_x && rd_y;
        cand.left_range  = x;
        cand.right_range = y;
      end
      default: begin
        en_j = rd_x && rd_y && y_multi;
        cand.left_range  = y;
        cand.right_range = x;
      end
    endcase
  end

  // output register feed
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    case (state)
      S_EMIT: begin
        if (en_j && pend_valid && out_free) begin
          push      = 1'b1;
          push_data = pend;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_valid) begin
            push_data      = pend;
            push_data.last = 1'b1;
          end else begin
            push_data.none_found = 1'b1;
            push_data.last       = 1'b1;
          end
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // memory write port: clearing pass or load word
  always_comb begin
    if (state == S_CLEAR) begin
      we = 1'b1;
      wa = clr_cnt;
      wd = 1'b1;
    end else begin
      we = req_fire && (req.action == ACT_LOAD);
      wa = r_ext[AREAS-1:0];
      wd = req.allowed;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_x <= mem[x_ext[AREAS-1:0]];
    rd_y <= mem[y_ext[AREAS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_count <= AREA_COUNT_RST;
    end else if (cfg_we) begin
      area_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      pend_valid <= 1'b0;
      i          <= '0;
      j          <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire && (req.action == ACT_QUERY)) begin
            range_q <= req.range_mask;
            vmask   <= vmask_next;
            lim     <= lim_next;
            i       <= '0;
            pend.left_range  <= req.range_mask;
            pend.right_range <= req.range_mask;
            pend.none_found  <= 1'b0;
            pend.last        <= 1'b0;
            pend_valid       <= single;
            if (single || (req.range_mask == '0)) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          j <= '0;
          if (!i_lt) begin
            state <= S_FINISH;
          end else if (range_q[i]) begin
            state <= S_EMIT;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_EMIT: begin
          if (!en_j || !pend_valid || out_free) begin
            if (en_j) begin
              pend       <= cand;
              pend_valid <= 1'b1;
            end
            if (j == 2'd3) begin
              state <= S_SCAN;
              i     <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !rsp_valid)
    else $error("word on rsp during clearing pass");

  a_none_shape: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.none_found) |->
      (rsp.last && (rsp.left_range == '0) && (rsp.right_range == '0)))
    else $error("none_found word not empty and last");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> i_lt && range_q[i])
    else $error("emitting for an area outside the range");

  a_finish_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (state == S_IDLE) && rsp_valid && rsp.last)
    else $error("query did not close with a last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !push)
    else $error("pending word overwritten");

endmodule
